>>> src/aeske_pkg.sv
// ----------------------------------------------------------------------------
// aeske_pkg
// shared types, constants and tables for the aes-128 key expansion block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aeske_pkg;

  localparam int WORD_W    = 32;
  localparam int INDEX_W   = 6;
  localparam int NUM_WORDS = 44;
  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(NUM_WORDS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_last;
  } dp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // round constant, selected by round number minus one
  function automatic logic [7:0] round_const(input logic [3:0] r);
    logic [7:0] rc;
    case (r)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1b;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

>>> src/aeske_ctrl.sv
// ----------------------------------------------------------------------------
// aeske_ctrl
// run controller: takes a key, then steps the schedule until the last word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aeske_ctrl import aeske_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!out_stall && status.at_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> src/aeske_dpath.sv
// ----------------------------------------------------------------------------
// aeske_dpath
// four-word schedule window with one next-word unit and the word counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aeske_dpath import aeske_pkg::*; (
  input  logic                clk,
  input  logic [63:0]         key_upper,
  input  logic [63:0]         key_lower,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic [INDEX_W-1:0]  word_index,
  output logic [WORD_W-1:0]   schedule_word,
  output logic                last_word
);

  // win[0] is the word being shown, win[3] the newest
  logic [WORD_W-1:0]  win [4];
  logic [INDEX_W-1:0] index;
  logic [WORD_W-1:0]  temp;
  logic [WORD_W-1:0]  word_next;

  // next word is index+4; it takes the rotate/sub/rcon path when index is a multiple of 4
  always_comb begin
    temp = win[3];
    if (index[1:0] == 2'b00) begin
      temp = sub_word({win[3][23:0], win[3][31:24]}) ^
             {round_const(index[5:2]), 24'h000000};
    end
    word_next = win[0] ^ temp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win[0] <= key_upper[63:32];
      win[1] <= key_upper[31:0];
      win[2] <= key_lower[63:32];
      win[3] <= key_lower[31:0];
      index  <= '0;
    end else if (cmd.advance) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= word_next;
      index  <= index + INDEX_W'(1);
    end
  end

  assign status.at_last = (index == LAST_INDEX);
  assign word_index     = index;
  assign schedule_word  = win[0];
  assign last_word      = status.at_last;

endmodule

>>> src/aes128_key_expansion.sv
// ----------------------------------------------------------------------------
// aes128_key_expansion
// latency: first schedule word is valid the cycle after the key is taken
// throughput: 44 words at one per cycle without stall, set by the single
//   next-word unit that walks the schedule serially
// reset: synchronous, clears the controller to idle; the window holds no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_key_expansion import aeske_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // key channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        key_upper,
  input  logic [63:0]        key_lower,
  // schedule word channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] word_index,
  output logic [WORD_W-1:0]  schedule_word,
  output logic               last_word
);

  // one key item in flight at a time: the key is held in a four-word window
  // that shifts once per delivered word, so the shown word always sits in
  // a register and holds while the output side stalls

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: idle until a key item arrives, then run until word 43 is taken
  aeske_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: window registers, word counter and the next-word logic
  // (rotate, s-box per byte, round constant, xor with word four back)
  aeske_dpath u_dpath (
    .clk           (clk),
    .key_upper     (key_upper),
    .key_lower     (key_lower),
    .cmd           (cmd),
    .status        (status),
    .word_index    (word_index),
    .schedule_word (schedule_word),
    .last_word     (last_word)
  );

endmodule

>>> bench/aes128_key_expansion_tb.sv
// ----------------------------------------------------------------------------
// aes128_key_expansion_tb
// self-checking bench for the aes-128 key expansion block: every key taken on
// the key channel is expanded here into its 44 round-key words, and each word
// leaving the block is checked in order against them. the s-box used for the
// expansion is derived from field inversion and the affine map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_key_expansion_tb import aeske_pkg::*;;

  localparam int CLK_PERIOD  = 10;
  localparam int RST_CYCLES  = 7;
  localparam int IDLE_PCT    = 12;   // chance per cycle that a side sits out
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int STALL_LIMIT = 1000; // cycles with no item moving on either side
  localparam int TAIL_CYCLES = 10;   // quiet cycles after the last word

  // one expected word of the schedule
  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
    logic               last;
  } sched_word_t;

  // dut signals, all inputs known from time zero
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [63:0]        key_upper = '0;
  logic [63:0]        key_lower = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [INDEX_W-1:0] word_index;
  logic [WORD_W-1:0]  schedule_word;
  logic               last_word;

  // bench state
  sched_word_t pending_words[$];   // words still owed by the block, oldest first
  logic [7:0]  sbox_tab [256];     // forward s-box, built at time zero
  int          errors        = 0;
  int          keys_sent     = 0;
  int          words_checked = 0;
  int          quiet_cycles  = 0;  // cycles since any item moved
  int          hold_left     = 0;  // receiver hold-off, counted down by its process
  bit          calm          = 1'b0; // no random idling on either side
  bit          key_offered   = 1'b0; // mirrors the intended value of in_valid

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  aes128_key_expansion i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key_upper     (key_upper),
    .key_lower     (key_lower),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_index    (word_index),
    .schedule_word (schedule_word),
    .last_word     (last_word)
  );

  // --------------------------------------------------------------------------
  // schedule prediction
  // --------------------------------------------------------------------------

  // multiply in gf(2^8) modulo the aes polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] x;
    prod = '0;
    x    = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) prod ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return prod;
  endfunction

  // s-box = affine map of the multiplicative inverse, zero maps to zero first
  function automatic void build_sbox();
    logic [7:0] inv;
    for (int b = 0; b < 256; b++) begin
      inv = '0;
      for (int c = 1; c < 256; c++)
        if (gf_mul(8'(b), 8'(c)) == 8'h01) inv = 8'(c);
      sbox_tab[b] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  endfunction

  // expand one key into its 44 words and queue them in order
  function automatic void expand_key(input logic [63:0] upper, input logic [63:0] lower);
    logic [WORD_W-1:0] w [NUM_WORDS];
    logic [WORD_W-1:0] t;
    logic [7:0]        rcon;
    sched_word_t       e;
    w[0] = upper[63:32];
    w[1] = upper[31:0];
    w[2] = lower[63:32];
    w[3] = lower[31:0];
    rcon = 8'h01;
    for (int i = 4; i < NUM_WORDS; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        // rotate left one byte, substitute each byte, fold in the round constant
        t = {t[23:0], t[31:24]};
        t = {sbox_tab[t[31:24]], sbox_tab[t[23:16]], sbox_tab[t[15:8]], sbox_tab[t[7:0]]};
        t ^= {rcon, 24'h000000};
        rcon = gf_mul(rcon, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < NUM_WORDS; i++) begin
      e.index = INDEX_W'(i);
      e.word  = w[i];
      e.last  = (i == NUM_WORDS - 1);
      pending_words.push_back(e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // key channel driver
  // --------------------------------------------------------------------------

  // only write in_valid when its value changes, so one write per time step
  task automatic drive_key_valid(input bit v);
    if (key_offered != v) begin
      in_valid    <= v;
      key_offered  = v;
    end
  endtask

  // offer one key and return at the edge where it is taken; valid stays up so
  // the next key can follow back to back
  task automatic send_key(input logic [63:0] upper, input logic [63:0] lower);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      drive_key_valid(1'b0);
      @(posedge clk);
    end
    drive_key_valid(1'b1);
    key_upper <= upper;
    key_lower <= lower;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_key(upper, lower);
    keys_sent++;
  endtask

  // drop valid and let every owed word come out
  task automatic drain_keys();
    drive_key_valid(1'b0);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // random key half with a few shapes: dense, single bit set or cleared, repeated byte
  function automatic logic [63:0] random_half();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = 64'h1 << $urandom_range(0, 63);
      1:       v = ~(64'h1 << $urandom_range(0, 63));
      2:       v = {8{8'($urandom_range(0, 255))}};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // schedule word channel: stall generation and checking
  // --------------------------------------------------------------------------

  // random stalls, plus a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // compare each word taken against the oldest expectation
  always @(posedge clk) begin
    sched_word_t e;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: index %0d, word %08h, last %0b",
               word_index, schedule_word, last_word);
        errors++;
      end else begin
        e = pending_words.pop_front();
        words_checked++;
        if (word_index !== e.index) begin
          $error("word_index mismatch: expected %0d, got %0d", e.index, word_index);
          errors++;
        end
        if (schedule_word !== e.word) begin
          $error("schedule_word mismatch: expected %08h, got %08h", e.word, schedule_word);
          errors++;
        end
        if (last_word !== e.last) begin
          $error("last_word mismatch: expected %0b, got %0b", e.last, last_word);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles, %0d words owed",
             STALL_LIMIT, pending_words.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // extremes and well-known keys
  task automatic test_directed_keys();
    send_key(64'h0000000000000000, 64'h0000000000000000);
    send_key(64'hffffffffffffffff, 64'hffffffffffffffff);
    // standard published example key
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    // lone bits at both ends of each half
    send_key(64'h8000000000000000, 64'h0000000000000001);
    send_key(64'h0000000000000001, 64'h8000000000000000);
    send_key(64'hffffffffffffffff, 64'h0000000000000000);
    send_key(64'h0000000000000000, 64'hffffffffffffffff);
    drain_keys();
  endtask

  // keys back to back with no idling on either side
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (20) send_key(random_half(), random_half());
    drain_keys();
    calm = 1'b0;
  endtask

  // receiver holds off while keys keep coming, so the block backs up
  task automatic test_fill_and_stall();
    hold_left = HOLD_CYCLES;
    repeat (6) send_key(random_half(), random_half());
    drain_keys();
  endtask

  // sender waits for every word of the previous key before the next one
  task automatic test_drain_between();
    repeat (8) begin
      send_key(random_half(), random_half());
      drain_keys();
    end
  endtask

  // random keys with idling on both sides
  task automatic test_random_keys();
    repeat (70) send_key(random_half(), random_half());
    drain_keys();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    build_sbox();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_keys();
    test_back_to_back();
    test_fill_and_stall();
    test_drain_between();
    test_random_keys();

    // let any stray word show up before closing
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d schedule words never arrived", pending_words.size());
      errors++;
    end

    $display("covered %0d keys (extremes, back to back, long hold-off, drained, random),",
             keys_sent);
    $display("%0d schedule words checked, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/aeske_pkg.sv
src/aeske_ctrl.sv
src/aeske_dpath.sv
src/aes128_key_expansion.sv
bench/aes128_key_expansion_tb.sv
